### rtl/hsatc_pkg.sv
`timescale 1ns / 1ps
package hsatc_pkg;

   localparam int ZOOM_W  = 5;
   localparam int COORD_W = 30;
   localparam int STAMP_W = 32;

   localparam logic [1:0] OP_PROBE = 2'd0;
   localparam logic [1:0] OP_TOUCH = 2'd1;
   localparam logic [1:0] OP_LOAD  = 2'd2;

   typedef enum logic [2:0] {
      ST_HIT    = 3'd0,
      ST_MISS   = 3'd1,
      ST_FILL   = 3'd2,
      ST_EVICT  = 3'd3,
      ST_REFUSE = 3'd4
   } status_type;

   localparam logic [31:0] HASH_ZOOM_C = 32'h9e37_79b9;
   localparam logic [31:0] HASH_COL_C  = 32'h85eb_ca6b;
   localparam logic [31:0] HASH_ROW_C  = 32'hc2b2_ae35;
   localparam logic [31:0] HASH_MIX_C  = 32'h7feb_352d;

   typedef struct packed {
      logic [ZOOM_W-1:0]  zoom;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

endpackage

### rtl/hashed_set_assoc_tile_cache.sv
`timescale 1ns / 1ps
// one request at a time: req_ready is high only in the idle state, so no new request is taken
//   until the last one has its response registered; hashing runs on one shared multiplier,
//   then one tag/stamp memory read and compare per way
// reset: synchronous, active high; afterwards a clearing pass over all NUM_SETS*WAYS entries
//   zeroes the valid memory, one entry a cycle, with req_ready low throughout
module hashed_set_assoc_tile_cache
   import hsatc_pkg::*;
#(
   parameter int NUM_SETS = 64,
   parameter int WAYS     = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_operation,
   input  logic [ZOOM_W-1:0]    req_zoom,
   input  logic [COORD_W-1:0]   req_tile_x,
   input  logic [COORD_W-1:0]   req_tile_y,
   input  logic                 req_prewarm,
   input  logic [STAMP_W-1:0]   req_frame_now,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_status,
   output logic [((NUM_SETS > 1) ? $clog2(NUM_SETS) : 1)-1:0] rsp_set_index,
   output logic [$clog2(WAYS)-1:0] rsp_way,
   output logic [ZOOM_W-1:0]    rsp_evicted_zoom,
   output logic [COORD_W-1:0]   rsp_evicted_x,
   output logic [COORD_W-1:0]   rsp_evicted_y
);

   localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_W   = $clog2(WAYS);
   localparam int ENTRIES = NUM_SETS * WAYS;
   localparam int ADDR_W  = $clog2(ENTRIES);
   localparam logic [WAY_W-1:0]  LAST_WAY   = WAY_W'(WAYS - 1);
   localparam logic [ADDR_W-1:0] LAST_ENTRY = ADDR_W'(ENTRIES - 1);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_HASH, S_RD, S_CMP, S_DECIDE
   } state_type;

   state_type           state_ff;
   logic [ADDR_W-1:0]   clr_ff;
   logic [1:0]          op_ff;
   logic [ZOOM_W-1:0]   z_ff;
   logic [COORD_W-1:0]  x_ff;
   logic [COORD_W-1:0]  y_ff;
   logic                pre_ff;
   logic [STAMP_W-1:0]  now_ff;
   logic [SET_W-1:0]    set_ff;
   logic [ADDR_W-1:0]   base_ff;
   logic [WAY_W-1:0]    way_cnt_ff;
   logic                hit_ff;
   logic [WAY_W-1:0]    hit_way_ff;
   logic                empty_ff;
   logic [WAY_W-1:0]    empty_way_ff;
   logic [WAY_W-1:0]    old_way_ff;
   entry_type           old_entry_ff;

   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic [SET_W-1:0]    rsp_set_ff;
   logic [WAY_W-1:0]    rsp_way_ff;
   logic [ZOOM_W-1:0]   rsp_ez_ff;
   logic [COORD_W-1:0]  rsp_ex_ff;
   logic [COORD_W-1:0]  rsp_ey_ff;

   entry_type           tag_mem [ENTRIES];
   logic                valid_mem [ENTRIES];
   entry_type           rd_entry_ff;
   logic                rd_valid_ff;

   logic                req_fire;
   logic                out_free;
   logic                hash_done;
   logic [SET_W-1:0]    hash_set;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ADDR_W-1:0]   wr_addr;
   logic                tag_we;
   logic                valid_we;
   logic [ADDR_W-1:0]   valid_addr;
   logic                valid_data;
   entry_type           wr_entry;
   logic                tag_match;
   logic                recent;
   status_type          dec_status;
   logic [WAY_W-1:0]    dec_way;
   logic                dec_write;
   logic [ZOOM_W-1:0]   dec_ez;
   logic [COORD_W-1:0]  dec_ex;
   logic [COORD_W-1:0]  dec_ey;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   hsatc_set_hash #(
      .NUM_SETS (NUM_SETS),
      .SET_W    (SET_W)
   ) u_hash (
      .clock     (clock),
      .reset     (reset),
      .start     (req_fire),
      .zoom      (z_ff),
      .tile_x    (x_ff),
      .tile_y    (y_ff),
      .done      (hash_done),
      .set_index (hash_set)
   );

   assign rd_addr = base_ff + ADDR_W'(way_cnt_ff);

   assign tag_match = rd_valid_ff && (rd_entry_ff.zoom == z_ff) &&
                      (rd_entry_ff.col == x_ff) && (rd_entry_ff.row == y_ff);

   // recency test is done one bit wider so that a full stamp never wraps
   assign recent = ({1'b0, old_entry_ff.stamp} + 33'd1) >= {1'b0, now_ff};

   always_comb begin
      dec_status = ST_MISS;
      dec_way    = '0;
      dec_write  = 1'b0;
      dec_ez     = '0;
      dec_ex     = '0;
      dec_ey     = '0;
      if (hit_ff) begin
         dec_status = ST_HIT;
         dec_way    = hit_way_ff;
         dec_write  = (op_ff == OP_TOUCH) || (op_ff == OP_LOAD);
      end else if (op_ff == OP_LOAD) begin
         priority if (empty_ff) begin
            dec_status = ST_FILL;
            dec_way    = empty_way_ff;
            dec_write  = 1'b1;
         end else if (pre_ff && recent) begin
            dec_status = ST_REFUSE;
         end else begin
            dec_status = ST_EVICT;
            dec_way    = old_way_ff;
            dec_write  = 1'b1;
            dec_ez     = old_entry_ff.zoom;
            dec_ex     = old_entry_ff.col;
            dec_ey     = old_entry_ff.row;
         end
      end
   end

   assign wr_addr        = base_ff + ADDR_W'(dec_way);
   assign wr_entry.zoom  = z_ff;
   assign wr_entry.col   = x_ff;
   assign wr_entry.row   = y_ff;
   assign wr_entry.stamp = now_ff;
   assign tag_we         = (state_ff == S_DECIDE) && out_free && dec_write;
   assign valid_we       = (state_ff == S_CLEAR) || tag_we;
   assign valid_addr     = (state_ff == S_CLEAR) ? clr_ff : wr_addr;
   assign valid_data     = (state_ff != S_CLEAR);

   always_ff @(posedge clock) begin
      if (tag_we) tag_mem[wr_addr] <= wr_entry;
      rd_entry_ff <= tag_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (valid_we) valid_mem[valid_addr] <= valid_data;
      rd_valid_ff <= valid_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new response in S_DECIDE takes the place of the one leaving
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DECIDE)) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + ADDR_W'(1);
               if (clr_ff == LAST_ENTRY) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_fire) begin
                  op_ff      <= req_operation;
                  z_ff       <= req_zoom;
                  x_ff       <= req_tile_x;
                  y_ff       <= req_tile_y;
                  pre_ff     <= req_prewarm;
                  now_ff     <= req_frame_now;
                  hit_ff     <= 1'b0;
                  empty_ff   <= 1'b0;
                  way_cnt_ff <= '0;
                  state_ff   <= S_HASH;
               end
            end
            S_HASH: begin
               if (hash_done) begin
                  set_ff   <= hash_set;
                  base_ff  <= ADDR_W'(hash_set) * ADDR_W'(WAYS);
                  state_ff <= S_RD;
               end
            end
            S_RD: state_ff <= S_CMP;
            S_CMP: begin
               if (!hit_ff && tag_match) begin
                  hit_ff     <= 1'b1;
                  hit_way_ff <= way_cnt_ff;
               end
               if (!rd_valid_ff && !empty_ff) begin
                  empty_ff     <= 1'b1;
                  empty_way_ff <= way_cnt_ff;
               end
               // oldest stamp, ties to the lower way; only used when every way is valid
               if ((way_cnt_ff == '0) || (rd_entry_ff.stamp < old_entry_ff.stamp)) begin
                  old_way_ff   <= way_cnt_ff;
                  old_entry_ff <= rd_entry_ff;
               end
               if (way_cnt_ff == LAST_WAY) begin
                  state_ff <= S_DECIDE;
               end else begin
                  way_cnt_ff <= way_cnt_ff + WAY_W'(1);
                  state_ff   <= S_RD;
               end
            end
            S_DECIDE: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= dec_status;
                  rsp_set_ff    <= set_ff;
                  rsp_way_ff    <= dec_way;
                  rsp_ez_ff     <= dec_ez;
                  rsp_ex_ff     <= dec_ex;
                  rsp_ey_ff     <= dec_ey;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_set_index    = rsp_set_ff;
   assign rsp_way          = rsp_way_ff;
   assign rsp_evicted_zoom = rsp_ez_ff;
   assign rsp_evicted_x    = rsp_ex_ff;
   assign rsp_evicted_y    = rsp_ey_ff;

endmodule

### rtl/hsatc_set_hash.sv
`timescale 1ns / 1ps
module hsatc_set_hash
   import hsatc_pkg::*;
#(
   parameter int NUM_SETS = 64,
   parameter int SET_W    = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [ZOOM_W-1:0]  zoom,
   input  logic [COORD_W-1:0] tile_x,
   input  logic [COORD_W-1:0] tile_y,
   output logic               done,
   output logic [SET_W-1:0]   set_index
);

   // remainder before correction stays below twice the set count
   localparam int RW = $clog2(NUM_SETS) + 1;
   localparam logic [31:0] RECIP_C =
      (NUM_SETS > 1) ? 32'(64'h1_0000_0000 / 64'(NUM_SETS)) : 32'd0;
   localparam logic [31:0] NSETS_C = 32'(NUM_SETS);
   localparam logic [RW-1:0] NSETS_R = RW'(NUM_SETS);

   typedef enum logic [2:0] {
      H_IDLE, H_MZ, H_MX, H_MY, H_MIX, H_QEST, H_QMUL, H_FIX
   } hstate_type;

   hstate_type      state_ff, state_in;
   logic [31:0]     h_ff, h_in;
   logic [31:0]     q_ff, q_in;
   logic [RW-1:0]   r_ff, r_in;
   logic [31:0]     mul_a, mul_b;
   logic [63:0]     prod;
   logic [31:0]     t_mix;
   logic [31:0]     m_mix;
   logic [RW-1:0]   r_fix;

   // the one multiplier, shared by every multiply step of the hash and the modulo
   always_comb begin
      unique case (state_ff)
         H_MZ:    begin mul_a = 32'(zoom);   mul_b = HASH_ZOOM_C; end
         H_MX:    begin mul_a = 32'(tile_x); mul_b = HASH_COL_C;  end
         H_MY:    begin mul_a = 32'(tile_y); mul_b = HASH_ROW_C;  end
         H_MIX:   begin mul_a = h_ff;        mul_b = HASH_MIX_C;  end
         H_QEST:  begin mul_a = h_ff;        mul_b = RECIP_C;     end
         H_QMUL:  begin mul_a = q_ff;        mul_b = NSETS_C;     end
         default: begin mul_a = '0;          mul_b = '0;          end
      endcase
   end

   assign prod  = 64'(mul_a) * 64'(mul_b);
   assign t_mix = h_ff ^ prod[31:0];
   assign m_mix = prod[31:0];
   assign r_fix = (r_ff >= NSETS_R) ? (r_ff - NSETS_R) : r_ff;

   always_comb begin
      state_in = state_ff;
      h_in     = h_ff;
      q_in     = q_ff;
      r_in     = r_ff;
      unique case (state_ff)
         H_IDLE:  if (start) state_in = H_MZ;
         H_MZ:    begin h_in = prod[31:0];                  state_in = H_MX;   end
         H_MX:    begin h_in = t_mix;                       state_in = H_MY;   end
         H_MY:    begin h_in = t_mix ^ (t_mix >> 16);       state_in = H_MIX;  end
         H_MIX:   begin h_in = m_mix ^ (m_mix >> 15);       state_in = H_QEST; end
         H_QEST:  begin q_in = prod[63:32];                 state_in = H_QMUL; end
         H_QMUL:  begin r_in = RW'(h_ff - prod[31:0]);      state_in = H_FIX;  end
         H_FIX:   state_in = H_IDLE;
         default: state_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
      end else begin
         state_ff <= state_in;
      end
      h_ff <= h_in;
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign done      = (state_ff == H_FIX);
   assign set_index = SET_W'(r_fix);

endmodule

### rtl/hsatc_checker.sv
`timescale 1ns / 1ps
module hsatc_checker
   import hsatc_pkg::*;
#(
   parameter int NUM_SETS = 64,
   parameter int WAYS     = 4
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [2:0]           rsp_status,
   input logic [((NUM_SETS > 1) ? $clog2(NUM_SETS) : 1)-1:0] rsp_set_index,
   input logic [$clog2(WAYS)-1:0] rsp_way,
   input logic [ZOOM_W-1:0]    rsp_evicted_zoom,
   input logic [COORD_W-1:0]   rsp_evicted_x,
   input logic [COORD_W-1:0]   rsp_evicted_y
);

   // a waiting response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_set_index) && $stable(rsp_way) && $stable(rsp_evicted_x))
      else $error("response changed while stalled");

   // one request at a time: ready drops straight after an accepted transaction
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready held after request accept");

   // valid memory clearing pass keeps the block busy after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("ready during clearing pass");

   a_evict_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_EVICT) |->
         (rsp_evicted_zoom == '0) && (rsp_evicted_x == '0) && (rsp_evicted_y == '0))
      else $error("evicted tag shown without eviction");

   a_no_way_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == ST_MISS) || (rsp_status == ST_REFUSE)) |->
         (rsp_way == '0))
      else $error("way reported without hit or fill");

endmodule

bind hashed_set_assoc_tile_cache hsatc_checker #(
   .NUM_SETS (NUM_SETS),
   .WAYS     (WAYS)
) u_hsatc_checker (.*);

### tb/tb_hashed_set_assoc_tile_cache.sv
`timescale 1ns / 1ps
module tb_hashed_set_assoc_tile_cache;
   import hsatc_pkg::*;

   localparam int SETS        = 64;
   localparam int NWAYS       = 4;
   localparam int RANDOM_REQS = 1500;
   localparam int CALM_REQS   = 150;
   localparam logic [1:0] OP_SPARE = 2'd3;

   typedef struct packed {
      logic [ZOOM_W-1:0]  zoom;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } tile_type;

   typedef struct packed {
      status_type         status;
      logic [5:0]         set_index;
      logic [1:0]         way;
      logic [ZOOM_W-1:0]  ev_zoom;
      logic [COORD_W-1:0] ev_col;
      logic [COORD_W-1:0] ev_row;
   } cache_outcome_type;

   typedef struct {
      logic [1:0]   op;
      tile_type     tile;
      logic         pre;
      logic [31:0]  frame;
      bit           pinned;
      status_type   st;
      logic [1:0]   way;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_operation;
   logic [ZOOM_W-1:0]    req_zoom;
   logic [COORD_W-1:0]   req_tile_x;
   logic [COORD_W-1:0]   req_tile_y;
   logic                 req_prewarm;
   logic [STAMP_W-1:0]   req_frame_now;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [2:0]           rsp_status;
   logic [5:0]           rsp_set_index;
   logic [1:0]           rsp_way;
   logic [ZOOM_W-1:0]    rsp_evicted_zoom;
   logic [COORD_W-1:0]   rsp_evicted_x;
   logic [COORD_W-1:0]   rsp_evicted_y;

   // shadow copy of the tag store
   bit                   tag_valid [SETS*NWAYS];
   bit [ZOOM_W-1:0]      tag_zoom  [SETS*NWAYS];
   bit [COORD_W-1:0]     tag_col   [SETS*NWAYS];
   bit [COORD_W-1:0]     tag_row   [SETS*NWAYS];
   bit [STAMP_W-1:0]     tag_stamp [SETS*NWAYS];

   cache_outcome_type    pending_outcomes [$];
   stim_row_type         directed_rows [$];
   tile_type             group [6];
   tile_type             hot_pool [32];
   int                   mismatch_count = 0;
   bit                   calm = 1'b0;

   hashed_set_assoc_tile_cache #(
      .NUM_SETS(SETS),
      .WAYS(NWAYS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_zoom(req_zoom),
      .req_tile_x(req_tile_x),
      .req_tile_y(req_tile_y),
      .req_prewarm(req_prewarm),
      .req_frame_now(req_frame_now),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_set_index(rsp_set_index),
      .rsp_way(rsp_way),
      .rsp_evicted_zoom(rsp_evicted_zoom),
      .rsp_evicted_x(rsp_evicted_x),
      .rsp_evicted_y(rsp_evicted_y)
   );

   always #10 clock = ~clock;

   function automatic logic [31:0] tile_hash(tile_type t);
      logic [31:0] h;
      h = {27'd0, t.zoom} * HASH_ZOOM_C;
      h ^= {2'b00, t.col} * HASH_COL_C;
      h ^= {2'b00, t.row} * HASH_ROW_C;
      h ^= h >> 16;
      h = h * HASH_MIX_C;
      h ^= h >> 15;
      return h;
   endfunction

   function automatic logic [5:0] set_of(tile_type t);
      return 6'(tile_hash(t) % SETS);
   endfunction

   // lookup, stamp and replacement on the shadow store
   function automatic cache_outcome_type predict_lookup(logic [1:0] op, tile_type t,
                                                        logic pre, logic [31:0] now);
      cache_outcome_type o;
      int base;
      int hit_way;
      int empty_way;
      int old_way;
      int e;
      o.status    = ST_MISS;
      o.set_index = set_of(t);
      o.way       = 2'd0;
      o.ev_zoom   = '0;
      o.ev_col    = '0;
      o.ev_row    = '0;
      base = int'(o.set_index) * NWAYS;
      hit_way = -1;
      for (int w = 0; w < NWAYS; w++) begin
         e = base + w;
         if (hit_way < 0 && tag_valid[e] && tag_zoom[e] == t.zoom &&
             tag_col[e] == t.col && tag_row[e] == t.row)
            hit_way = w;
      end
      if (hit_way >= 0) begin
         o.status = ST_HIT;
         o.way    = 2'(hit_way);
         if (op == OP_TOUCH || op == OP_LOAD)
            tag_stamp[base + hit_way] = now;
      end else if (op == OP_LOAD) begin
         empty_way = -1;
         old_way   = 0;
         for (int w = 0; w < NWAYS; w++) begin
            e = base + w;
            if (!tag_valid[e]) begin
               if (empty_way < 0)
                  empty_way = w;
            end else if (tag_stamp[e] < tag_stamp[base + old_way]) begin
               old_way = w;
            end
         end
         if (empty_way >= 0) begin
            o.status = ST_FILL;
            o.way    = 2'(empty_way);
         end else if (pre && ({1'b0, tag_stamp[base + old_way]} + 33'd1 >= {1'b0, now})) begin
            // oldest way still warm, speculative fill refused
            o.status = ST_REFUSE;
         end else begin
            e = base + old_way;
            o.status  = ST_EVICT;
            o.way     = 2'(old_way);
            o.ev_zoom = tag_zoom[e];
            o.ev_col  = tag_col[e];
            o.ev_row  = tag_row[e];
         end
         if (o.status == ST_FILL || o.status == ST_EVICT) begin
            e = base + int'(o.way);
            tag_valid[e] = 1'b1;
            tag_zoom[e]  = t.zoom;
            tag_col[e]   = t.col;
            tag_row[e]   = t.row;
            tag_stamp[e] = now;
         end
      end
      return o;
   endfunction

   function automatic tile_type random_tile();
      tile_type t;
      t.zoom = 5'($urandom_range(0, 31));
      t.col  = 30'($urandom);
      t.row  = 30'($urandom);
      return t;
   endfunction

   task automatic add_row(input logic [1:0] op, input tile_type t, input logic pre,
                          input logic [31:0] frame, input bit pinned = 1'b0,
                          input status_type st = ST_HIT, input logic [1:0] way = 2'd0);
      stim_row_type r;
      r.op = op;
      r.tile = t;
      r.pre = pre;
      r.frame = frame;
      r.pinned = pinned;
      r.st = st;
      r.way = way;
      directed_rows.push_back(r);
   endtask

   task automatic issue_request(input logic [1:0] op, input tile_type t, input logic pre,
                                input logic [31:0] frame, input bit pinned,
                                input status_type st, input logic [1:0] way);
      cache_outcome_type o;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_zoom      <= t.zoom;
      req_tile_x    <= t.col;
      req_tile_y    <= t.row;
      req_prewarm   <= pre;
      req_frame_now <= frame;
      do @(posedge clock); while (!req_ready);
      o = predict_lookup(op, t, pre, frame);
      if (pinned) begin
         o.status = st;
         o.way    = way;
      end
      pending_outcomes.push_back(o);
   endtask

   task automatic sender_gap();
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic drain_outcomes();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // stimulus
   initial begin
      tile_type   t;
      tile_type   t_lo;
      tile_type   t_hi;
      logic [5:0] hot_sets [3];
      logic [1:0] op;
      logic [31:0] frame_cnt;
      int         n;
      int         r;

      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_operation <= OP_PROBE;
      req_zoom      <= '0;
      req_tile_x    <= '0;
      req_tile_y    <= '0;
      req_prewarm   <= 1'b0;
      req_frame_now <= '0;

      // six tiles that all land in one set
      group[0] = '{zoom: 5'd3, col: 30'd1000, row: 30'd7};
      n = 1;
      t = group[0];
      while (n < 6) begin
         t.col = t.col + 30'd1;
         if (set_of(t) == set_of(group[0])) begin
            group[n] = t;
            n++;
         end
      end

      t_lo = '{zoom: 5'd0, col: 30'd0, row: 30'd0};
      t_hi = '{zoom: 5'd31, col: '1, row: '1};
      add_row(OP_PROBE, t_lo, 1'b0, 32'd0, 1'b1, ST_MISS, 2'd0);
      add_row(OP_SPARE, t_hi, 1'b1, 32'hFFFF_FFFF, 1'b1, ST_MISS, 2'd0);
      add_row(OP_TOUCH, group[0], 1'b0, 32'd10, 1'b1, ST_MISS, 2'd0);
      add_row(OP_LOAD, group[0], 1'b0, 32'd10, 1'b1, ST_FILL, 2'd0);
      add_row(OP_LOAD, group[1], 1'b1, 32'd10, 1'b1, ST_FILL, 2'd1);
      add_row(OP_LOAD, group[2], 1'b0, 32'd11, 1'b1, ST_FILL, 2'd2);
      add_row(OP_LOAD, group[3], 1'b0, 32'd12, 1'b1, ST_FILL, 2'd3);
      add_row(OP_PROBE, group[0], 1'b0, 32'd99, 1'b1, ST_HIT, 2'd0);
      add_row(OP_TOUCH, group[1], 1'b0, 32'd20, 1'b1, ST_HIT, 2'd1);
      // hit on a load only restamps
      add_row(OP_LOAD, group[0], 1'b1, 32'd21, 1'b1, ST_HIT, 2'd0);
      // oldest way stamped in the previous frame
      add_row(OP_LOAD, group[4], 1'b1, 32'd12, 1'b1, ST_REFUSE, 2'd0);
      add_row(OP_LOAD, group[4], 1'b1, 32'd13, 1'b1, ST_EVICT, 2'd2);
      // plain load evicts even with an older frame number
      add_row(OP_LOAD, group[5], 1'b0, 32'd5, 1'b1, ST_EVICT, 2'd3);
      add_row(OP_PROBE, group[2], 1'b0, 32'd6, 1'b1, ST_MISS, 2'd0);
      add_row(OP_LOAD, group[2], 1'b1, 32'd6, 1'b1, ST_REFUSE, 2'd0);
      // equal stamps, lower way wins
      add_row(OP_TOUCH, group[0], 1'b0, 32'd5, 1'b1, ST_HIT, 2'd0);
      add_row(OP_LOAD, group[2], 1'b0, 32'd100, 1'b1, ST_EVICT, 2'd0);
      add_row(OP_TOUCH, group[2], 1'b0, 32'hFFFF_FFFF);
      add_row(OP_TOUCH, group[1], 1'b0, 32'hFFFF_FFFF);
      add_row(OP_TOUCH, group[4], 1'b0, 32'hFFFF_FFFF);
      add_row(OP_TOUCH, group[5], 1'b0, 32'hFFFF_FFFF);
      // maximum stamp stays recent, no wrap
      add_row(OP_LOAD, group[3], 1'b1, 32'd0, 1'b1, ST_REFUSE, 2'd0);
      add_row(OP_LOAD, group[3], 1'b0, 32'd0, 1'b1, ST_EVICT, 2'd0);
      add_row(OP_SPARE, group[3], 1'b0, 32'd77);
      add_row(OP_LOAD, t_hi, 1'b1, 32'hFFFF_FFFF);

      // random pool concentrated on three sets so that ways fill and turn over
      hot_sets[0] = set_of(group[0]);
      hot_sets[1] = 6'($urandom_range(0, SETS - 1));
      hot_sets[2] = 6'($urandom_range(0, SETS - 1));
      for (int i = 0; i < 32; i++) begin
         t = random_tile();
         if (i < 22)
            while (set_of(t) != hot_sets[i % 3]) t = random_tile();
         hot_pool[i] = t;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         issue_request(directed_rows[i].op, directed_rows[i].tile, directed_rows[i].pre,
                       directed_rows[i].frame, directed_rows[i].pinned,
                       directed_rows[i].st, directed_rows[i].way);
         sender_gap();
      end
      drain_outcomes();

      frame_cnt = $urandom_range(0, 1000);
      for (int i = 0; i < RANDOM_REQS; i++) begin
         if (i == RANDOM_REQS / 2)
            drain_outcomes();
         if (i >= RANDOM_REQS - CALM_REQS)
            calm = 1'b1;
         r = $urandom_range(0, 99);
         if (r < 3)
            frame_cnt = $urandom;
         else if (r < 5)
            frame_cnt = 32'hFFFF_FFFF - $urandom_range(0, 3);
         else
            frame_cnt = frame_cnt + $urandom_range(0, 2);
         r = $urandom_range(0, 9);
         if (r < 5)
            op = OP_LOAD;
         else if (r < 7)
            op = OP_TOUCH;
         else if (r < 9)
            op = OP_PROBE;
         else
            op = OP_SPARE;
         if ($urandom_range(0, 4) == 0)
            t = random_tile();
         else
            t = hot_pool[$urandom_range(0, 31)];
         issue_request(op, t, 1'($urandom_range(0, 1)), frame_cnt, 1'b0, ST_HIT, 2'd0);
         sender_gap();
      end
      drain_outcomes();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // response side back-pressure
   initial begin
      forever begin
         rsp_ready <= 1'b1;
         repeat (($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30)) @(posedge clock);
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      cache_outcome_type o;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected transaction: status %0d set %0d way %0d",
                        rsp_status, rsp_set_index, rsp_way);
            mismatch_count++;
         end else begin
            o = pending_outcomes.pop_front();
            if (rsp_status !== o.status || rsp_set_index !== o.set_index ||
                rsp_way !== o.way || rsp_evicted_zoom !== o.ev_zoom ||
                rsp_evicted_x !== o.ev_col || rsp_evicted_y !== o.ev_row) begin
               if (mismatch_count < 10) begin
                  $display("mismatch: exp status %0d set %0d way %0d ev %0d/%h/%h",
                           o.status, o.set_index, o.way, o.ev_zoom, o.ev_col, o.ev_row);
                  $display("          got status %0d set %0d way %0d ev %0d/%h/%h",
                           rsp_status, rsp_set_index, rsp_way, rsp_evicted_zoom,
                           rsp_evicted_x, rsp_evicted_y);
               end
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

### hashed_set_assoc_tile_cache.f
rtl/hsatc_pkg.sv
rtl/hsatc_set_hash.sv
rtl/hashed_set_assoc_tile_cache.sv
rtl/hsatc_checker.sv
tb/tb_hashed_set_assoc_tile_cache.sv
